// File: rtl/yuv_plane_psnr_meter_assert.svh
// Assertion macros shared by the meter's modules.
`ifndef YUV_PLANE_PSNR_METER_ASSERT_SVH
`define YUV_PLANE_PSNR_METER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define YPM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("yuvpm check failed");

// next-cycle implication, checked out of reset
`define YPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("yuvpm check failed");

`endif

// File: rtl/yuvpm_pkg.sv
// Types and constants of the per-plane PSNR meter.
package yuvpm_pkg;

  localparam int MAX_DIM_DEF   = 4096;
  localparam int FRAC_BITS_DEF = 8;
  localparam int SSE_W         = 40;

  localparam logic [15:0] PEAK_SQ     = 16'd65025;
  localparam logic [25:0] TENLOG2_Q24 = 26'd50504453;
  localparam logic [14:0] PSNR_MAX    = 15'd32767;

  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_CHROMA_FULL  = 2'd2;

  localparam logic [1:0] PLANE_Y = 2'd0;
  localparam logic [1:0] PLANE_V = 2'd2;

  typedef struct packed {
    logic [7:0] orig_sample;
    logic [7:0] recon_sample;
  } in_t;

  typedef struct packed {
    logic [15:0]      frame_number;
    logic [1:0]       plane_id;
    logic [SSE_W-1:0] sum_sq_error;
    logic [14:0]      psnr_db_q8;
    logic             exact_match;
  } out_t;

  typedef struct packed {
    logic start;
  } log_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } log_rsp_t;

endpackage

// File: rtl/yuvpm_log_unit.sv
// Iterative PSNR unit: normalise, divide, log2 by squaring, scale and round.
module yuvpm_log_unit #(
  parameter int NUM_W     = 42,
  parameter int FRAC_BITS = yuvpm_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  yuvpm_pkg::log_req_t           req,
  output yuvpm_pkg::log_rsp_t           rsp,
  input  logic [NUM_W-1:0]              num_i,
  input  logic [yuvpm_pkg::SSE_W-1:0]   den_i,
  output logic [14:0]                   psnr_o
);

  localparam int CMP_W = (NUM_W > yuvpm_pkg::SSE_W) ? NUM_W : yuvpm_pkg::SSE_W;
  localparam int K_W   = $clog2(NUM_W + 1);
  localparam int LG_W  = K_W + 28;
  localparam int LO_W  = 17;
  localparam int HI_W  = LG_W - LO_W;
  localparam int ACC_W = LG_W + 26;
  localparam int SUM_W = ACC_W + 1;
  localparam int RS    = 52 - FRAC_BITS;

  typedef enum logic [6:0] {
    U_IDLE = 7'b0000001,
    U_NORM = 7'b0000010,
    U_DIV  = 7'b0000100,
    U_LOG  = 7'b0001000,
    U_MLO  = 7'b0010000,
    U_MHI  = 7'b0100000,
    U_RND  = 7'b1000000
  } ustate_t;

  ustate_t           state_r, state_nxt;
  logic [NUM_W-1:0]  d_r, d_nxt;
  logic [NUM_W:0]    r_r, r_nxt;
  logic [30:0]       y_r, y_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic [LG_W-1:0]   lg_r, lg_nxt;
  logic [4:0]        it_r, it_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;

  logic [31:0]       mul_a, mul_b;
  logic [63:0]       prod;
  logic [31:0]       yy;
  logic              ge;
  logic [NUM_W:0]    rsub;
  logic [SUM_W-1:0]  rsum, rsh;

  // the one shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      U_LOG: begin
        mul_a = {1'b0, y_r};
        mul_b = {1'b0, y_r};
      end
      U_MLO: begin
        mul_a = 32'(lg_r[LO_W-1:0]);
        mul_b = 32'(yuvpm_pkg::TENLOG2_Q24);
      end
      U_MHI: begin
        mul_a = 32'(lg_r[LG_W-1:LO_W]);
        mul_b = 32'(yuvpm_pkg::TENLOG2_Q24);
      end
      default: begin
      end
    endcase
  end
  assign prod = mul_a * mul_b;
  assign yy   = prod[61:30];

  assign ge   = r_r >= {1'b0, d_r};
  assign rsub = ge ? (r_r - {1'b0, d_r}) : r_r;

  assign rsum = {1'b0, acc_r} + (SUM_W'(1) << (RS - 1));
  assign rsh  = rsum >> RS;

  always_comb begin
    state_nxt = state_r;
    d_nxt     = d_r;
    r_nxt     = r_r;
    y_nxt     = y_r;
    k_nxt     = k_r;
    lg_nxt    = lg_r;
    it_nxt    = it_r;
    acc_nxt   = acc_r;
    case (state_r)
      U_IDLE: begin
        if (req.start) begin
          if (CMP_W'(num_i) < CMP_W'(den_i)) begin
            acc_nxt   = '0;
            state_nxt = U_RND;
          end else begin
            d_nxt     = NUM_W'(den_i);
            k_nxt     = '0;
            state_nxt = U_NORM;
          end
        end
      end
      U_NORM: begin
        if ({d_r, 1'b0} <= {1'b0, num_i}) begin
          d_nxt = {d_r[NUM_W-2:0], 1'b0};
          k_nxt = k_r + K_W'(1);
        end else begin
          r_nxt     = {1'b0, num_i};
          y_nxt     = '0;
          it_nxt    = '0;
          state_nxt = U_DIV;
        end
      end
      U_DIV: begin
        y_nxt  = {y_r[29:0], ge};
        r_nxt  = {rsub[NUM_W-1:0], 1'b0};
        it_nxt = it_r + 5'd1;
        if (it_r == 5'd30) begin
          it_nxt    = '0;
          lg_nxt    = LG_W'(k_r);
          state_nxt = U_LOG;
        end
      end
      U_LOG: begin
        // square; a carry past 2.0 yields the next fraction bit
        y_nxt  = yy[31] ? yy[31:1] : yy[30:0];
        lg_nxt = {lg_r[LG_W-2:0], yy[31]};
        it_nxt = it_r + 5'd1;
        if (it_r == 5'd27) state_nxt = U_MLO;
      end
      U_MLO: begin
        acc_nxt   = ACC_W'(prod[LO_W+25:0]);
        state_nxt = U_MHI;
      end
      U_MHI: begin
        acc_nxt   = acc_r + (ACC_W'(prod[HI_W+25:0]) << LO_W);
        state_nxt = U_RND;
      end
      U_RND: begin
        state_nxt = U_IDLE;
      end
      default: state_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      it_r    <= '0;
    end else begin
      state_r <= state_nxt;
      it_r    <= it_nxt;
    end
    d_r   <= d_nxt;
    r_r   <= r_nxt;
    y_r   <= y_nxt;
    k_r   <= k_nxt;
    lg_r  <= lg_nxt;
    acc_r <= acc_nxt;
  end

  assign rsp.busy = (state_r != U_IDLE);
  assign rsp.done = (state_r == U_RND);
  assign psnr_o   = (rsh > SUM_W'(yuvpm_pkg::PSNR_MAX)) ? yuvpm_pkg::PSNR_MAX : rsh[14:0];

`include "yuv_plane_psnr_meter_assert.svh"
  `YPM_ASSERT_NOW(a_start_idle, req.start, state_r == U_IDLE)
  `YPM_ASSERT_NEXT(a_done_returns, state_r == U_RND, state_r == U_IDLE)
  `YPM_ASSERT_NEXT(a_div_to_log, (state_r == U_DIV) && (it_r == 5'd30),
                   (state_r == U_LOG) && (it_r == 5'd0))

endmodule

// File: rtl/yuv_plane_psnr_meter.sv
// Top level of the per-plane PSNR meter: sample accumulation, sequencing, result register.
//
// Usage: samples arrive as original/reconstructed pairs on in_* in planar
// Y, U, V order; a request is taken when in_valid is high and in_stall low.
// Plane sizes follow cfg registers 0 (width), 1 (height), 2 (chroma_full),
// written over cfg_valid/cfg_ready while the block is idle, a rule on the
// user that the block does not enforce; cfg_ready is always high.
// Throughput: one sample per cycle inside a plane. The sample that closes a
// plane starts the shared PSNR unit (normalise loop of up to 40 steps, 31
// divide steps, 28 squaring steps on the single multiplier, two scaling
// products and a round); in_stall is then high until the result is emitted,
// and the unit skips its loops when the error exceeds the peak energy. A
// zero-error plane skips the unit. The result goes via a pending register to
// out_*, held until taken (out_valid high, out_stall low); a stalled result
// keeps in_stall high only once the next plane result is ready to leave.
// Reset (rst_n low, synchronous) returns the block to the Y plane of frame 0
// with a cleared sum and the default 432x240 4:2:0 geometry.
module yuv_plane_psnr_meter #(
  parameter int MAX_DIM        = yuvpm_pkg::MAX_DIM_DEF,
  parameter int PSNR_FRAC_BITS = yuvpm_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  yuvpm_pkg::in_t    in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output yuvpm_pkg::out_t   out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [12:0]       cfg_data
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int N_W   = 2 * DIM_W;
  localparam int NUM_W = N_W + 16;
  localparam int CL_W  = (DIM_W > 13) ? DIM_W : 13;
  localparam int SW    = yuvpm_pkg::SSE_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PREP  = 5'b00010,
    S_START = 5'b00100,
    S_CALC  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [12:0]       width_r, height_r;
  logic              full_r;
  logic [N_W-1:0]    cnt_r;
  logic [1:0]        plane_r;
  logic [SW-1:0]     sse_r;
  logic [15:0]       frame_r;
  logic [N_W-1:0]    n_r;
  logic [NUM_W-1:0]  num_r;
  yuvpm_pkg::out_t   pend_r;
  yuvpm_pkg::out_t   out_r;
  logic              out_valid_r;

  logic [CL_W-1:0]   wx, hx;
  logic [DIM_W-1:0]  w_cl, h_cl, mw, mh;
  logic [N_W-1:0]    n_plane;
  logic [7:0]        diff;
  logic [15:0]       sq;
  logic [SW:0]       sse_sum;
  logic [SW-1:0]     sse_new;
  logic [N_W:0]      cnt_inc;
  logic              in_acc, plane_end, slot_free, emit;

  yuvpm_pkg::log_req_t lreq;
  yuvpm_pkg::log_rsp_t lrsp;
  logic [14:0]         lpsnr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 13'd432;
      height_r <= 13'd240;
      full_r   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        yuvpm_pkg::CFG_FRAME_WIDTH:  width_r  <= cfg_data;
        yuvpm_pkg::CFG_FRAME_HEIGHT: height_r <= cfg_data;
        yuvpm_pkg::CFG_CHROMA_FULL:  full_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // clamp geometry to [2, MAX_DIM]
  always_comb begin
    wx = CL_W'(width_r);
    hx = CL_W'(height_r);
    if (wx < CL_W'(2))            wx = CL_W'(2);
    else if (wx > CL_W'(MAX_DIM)) wx = CL_W'(MAX_DIM);
    if (hx < CL_W'(2))            hx = CL_W'(2);
    else if (hx > CL_W'(MAX_DIM)) hx = CL_W'(MAX_DIM);
    w_cl = DIM_W'(wx);
    h_cl = DIM_W'(hx);
    if (plane_r == yuvpm_pkg::PLANE_Y || full_r) begin
      mw = w_cl;
      mh = h_cl;
    end else begin
      mw = DIM_W'(({1'b0, w_cl} + (DIM_W + 1)'(1)) >> 1);
      mh = DIM_W'(({1'b0, h_cl} + (DIM_W + 1)'(1)) >> 1);
    end
  end
  assign n_plane = N_W'(mw) * N_W'(mh);

  assign diff    = (in_data.orig_sample >= in_data.recon_sample) ?
                   (in_data.orig_sample - in_data.recon_sample) :
                   (in_data.recon_sample - in_data.orig_sample);
  assign sq      = 16'(diff) * 16'(diff);
  assign sse_sum = {1'b0, sse_r} + (SW + 1)'(sq);
  assign sse_new = sse_sum[SW] ? {SW{1'b1}} : sse_sum[SW-1:0];
  assign cnt_inc = {1'b0, cnt_r} + (N_W + 1)'(1);

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign plane_end = in_acc && (cnt_inc >= {1'b0, n_plane});
  assign slot_free = !out_valid_r || !out_stall;
  assign emit      = (state_r == S_EMIT) && slot_free;
  assign lreq.start = (state_r == S_START);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (plane_end) state_nxt = (sse_new == '0) ? S_EMIT : S_PREP;
      S_PREP:  state_nxt = S_START;
      S_START: state_nxt = S_CALC;
      S_CALC:  if (lrsp.done) state_nxt = S_EMIT;
      S_EMIT:  if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      plane_r     <= yuvpm_pkg::PLANE_Y;
      sse_r       <= '0;
      frame_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (plane_end) begin
        cnt_r <= '0;
        sse_r <= '0;
        if (plane_r >= yuvpm_pkg::PLANE_V) begin
          plane_r <= yuvpm_pkg::PLANE_Y;
          frame_r <= frame_r + 16'd1;
        end else begin
          plane_r <= plane_r + 2'd1;
        end
      end else if (in_acc) begin
        cnt_r <= cnt_inc[N_W-1:0];
        sse_r <= sse_new;
      end
      if (emit)            out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // result fields; no reset needed
  always_ff @(posedge clk) begin
    if (plane_end) begin
      pend_r.frame_number <= frame_r;
      pend_r.plane_id     <= plane_r;
      pend_r.sum_sq_error <= sse_new;
      pend_r.exact_match  <= (sse_new == '0);
      pend_r.psnr_db_q8   <= yuvpm_pkg::PSNR_MAX;
      n_r                 <= n_plane;
    end else if ((state_r == S_CALC) && lrsp.done) begin
      pend_r.psnr_db_q8 <= lpsnr;
    end
    if (state_r == S_PREP) num_r <= NUM_W'(yuvpm_pkg::PEAK_SQ) * NUM_W'(n_r);
    if (emit) out_r <= pend_r;
  end

  yuvpm_log_unit #(
    .NUM_W     (NUM_W),
    .FRAC_BITS (PSNR_FRAC_BITS)
  ) u_log (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (lreq),
    .rsp    (lrsp),
    .num_i  (num_r),
    .den_i  (pend_r.sum_sq_error),
    .psnr_o (lpsnr)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`include "yuv_plane_psnr_meter_assert.svh"
  `YPM_ASSERT_NOW(a_calc_busy, (state_r == S_CALC) || (state_r == S_START),
                  (state_r == S_START) || lrsp.busy)
  `YPM_ASSERT_NOW(a_match_sse, out_valid_r,
                  out_r.exact_match == (out_r.sum_sq_error == '0))
  `YPM_ASSERT_NEXT(a_end_stalls, plane_end, in_stall && (cnt_r == '0))

endmodule
